### hdl/wsr_pkg.sv
package wsr_pkg;

   // Field and register widths
   localparam int REV_BITS = 32;
   localparam int REVS_W   = 32;
   localparam int CIRC_W   = 12;
   localparam int HOLD_W   = 4;
   localparam int TIME_W   = 16;
   localparam int SPEED_W  = 10;
   localparam int RUN_W    = HOLD_W + 1;
   localparam int IDX_W    = 1;
   localparam int CSR_W    = CIRC_W;

   // Datapath widths: num = revdiff * circ * 2304, den = 625 * tdiff
   localparam int PROD_W = REV_BITS + CIRC_W;
   localparam int NUM_W  = PROD_W + 12;
   localparam int DEN_W  = TIME_W + 10;
   localparam int LIM_W  = DEN_W + 10;
   localparam int QUO_W  = SPEED_W;
   localparam int REM_W  = DEN_W + 1 + QUO_W;
   localparam int CNT_W  = $clog2(QUO_W);

   localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(2130);
   localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(2);
   localparam logic [DEN_W-1:0]  TIME_SCALE = DEN_W'(625);

   // Configuration register indexes
   localparam logic [IDX_W-1:0] CSR_CIRC = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_HOLD = IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_SCALE,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } wsr_state_type;

   typedef struct packed {
      logic accept;
      logic clear_quo;
      logic mul;
      logic scale;
      logic prep;
      logic div_step;
      logic load_out;
   } wsr_cmd_type;

   typedef struct packed {
      logic emit_zero;
      logic emit_calc;
      logic div_skip;
      logic div_last;
   } wsr_sts_type;

endpackage

### hdl/wsr_ctrl.sv
module wsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  wsr_pkg::wsr_sts_type sts,
   output wsr_pkg::wsr_cmd_type cmd
);
   import wsr_pkg::*;

   wsr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.emit_zero) begin
               cmd.clear_quo = 1'b1;
               state_in      = ST_FIN;
            end else if (sts.emit_calc) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.div_skip ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // The output register takes the result once it is empty or being read.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.load_out;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/wsr_dp.sv
module wsr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  wsr_pkg::wsr_cmd_type          cmd,
   output wsr_pkg::wsr_sts_type          sts,
   input  logic                          csr_wr_en,
   input  logic [wsr_pkg::IDX_W-1:0]     csr_index,
   input  logic [wsr_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          req_wheel_present,
   input  logic [wsr_pkg::REVS_W-1:0]    req_wheel_revs,
   input  logic [wsr_pkg::TIME_W-1:0]    req_event_time,
   output logic [wsr_pkg::SPEED_W-1:0]   rsp_speed
);
   import wsr_pkg::*;

   // Configuration and sample history
   logic [CIRC_W-1:0]   circ_ff, circ_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic [REV_BITS-1:0] last_revs_ff, last_revs_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic [RUN_W-1:0]    zero_run_ff, zero_run_in;
   logic                has_prior_ff, has_prior_in;
   logic                emit_zero_ff, emit_zero_in;
   logic                emit_calc_ff, emit_calc_in;

   // Arithmetic payload
   logic [REV_BITS-1:0] revdiff_ff, revdiff_in;
   logic [TIME_W-1:0]   tdiff_ff, tdiff_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [LIM_W-1:0]    lim_ff, lim_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    dvs_ff, dvs_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;

   logic [REV_BITS-1:0] revs_new;
   logic [REV_BITS-1:0] revdiff_new;
   logic [RUN_W-1:0]    run_new;
   logic                over;
   logic                fits;
   logic [REM_W-1:0]    rem_sub;

   always_comb begin
      revs_new    = req_wheel_revs[REV_BITS-1:0];
      revdiff_new = revs_new - last_revs_ff;
      if (revdiff_new == '0) begin
         run_new = (zero_run_ff <= RUN_W'(hold_ff)) ? zero_run_ff + RUN_W'(1) : zero_run_ff;
      end else begin
         run_new = '0;
      end

      over    = (den_ff == '0) || (num_ff > NUM_W'(lim_ff));
      fits    = (rem_ff >= dvs_ff);
      rem_sub = rem_ff - dvs_ff;

      circ_in      = circ_ff;
      hold_in      = hold_ff;
      last_revs_in = last_revs_ff;
      last_time_in = last_time_ff;
      zero_run_in  = zero_run_ff;
      has_prior_in = has_prior_ff;
      emit_zero_in = emit_zero_ff;
      emit_calc_in = emit_calc_ff;
      revdiff_in   = revdiff_ff;
      tdiff_in     = tdiff_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      lim_in       = lim_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      speed_in     = speed_ff;

      if (csr_wr_en) begin
         if (csr_index == CSR_CIRC) begin
            circ_in = csr_wdata[CIRC_W-1:0];
         end else if (csr_index == CSR_HOLD) begin
            hold_in = csr_wdata[HOLD_W-1:0];
         end
      end

      if (cmd.accept) begin
         emit_zero_in = 1'b0;
         emit_calc_in = 1'b0;
         if (req_wheel_present) begin
            revdiff_in   = revdiff_new;
            tdiff_in     = req_event_time - last_time_ff;
            zero_run_in  = run_new;
            emit_zero_in = !has_prior_ff || (run_new > RUN_W'(hold_ff));
            emit_calc_in = has_prior_ff && (run_new == '0);
            last_revs_in = revs_new;
            last_time_in = req_event_time;
            has_prior_in = 1'b1;
         end
      end

      if (cmd.clear_quo) begin
         quo_in = '0;
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(revdiff_ff) * PROD_W'(circ_ff);
         den_in  = DEN_W'(tdiff_ff) * TIME_SCALE;
      end

      if (cmd.scale) begin
         // 2304 = 2048 + 256 and 999 = 1024 - 16 - 8 - 1
         num_in = (NUM_W'(prod_ff) << 11) + (NUM_W'(prod_ff) << 8);
         lim_in = (LIM_W'(den_ff) << 10) - (LIM_W'(den_ff) << 4)
                - (LIM_W'(den_ff) << 3) - LIM_W'(den_ff);
      end

      if (cmd.prep) begin
         // Rounded quotient is floor((2*num + den) / (2*den)), below 2^QUO_W.
         rem_in = {num_ff[REM_W-2:0], 1'b0} + REM_W'(den_ff);
         dvs_in = REM_W'({den_ff, 1'b0}) << (QUO_W - 1);
         quo_in = '0;
         cnt_in = CNT_W'(QUO_W - 1);
      end

      if (cmd.div_step) begin
         if (fits) begin
            rem_in = rem_sub;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (cmd.load_out) begin
         speed_in = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff      <= CIRC_RESET;
         hold_ff      <= HOLD_RESET;
         last_revs_ff <= '0;
         last_time_ff <= '0;
         zero_run_ff  <= '0;
         has_prior_ff <= 1'b0;
         emit_zero_ff <= 1'b0;
         emit_calc_ff <= 1'b0;
      end else begin
         circ_ff      <= circ_in;
         hold_ff      <= hold_in;
         last_revs_ff <= last_revs_in;
         last_time_ff <= last_time_in;
         zero_run_ff  <= zero_run_in;
         has_prior_ff <= has_prior_in;
         emit_zero_ff <= emit_zero_in;
         emit_calc_ff <= emit_calc_in;
      end
   end

   always_ff @(posedge clock) begin
      revdiff_ff <= revdiff_in;
      tdiff_ff   <= tdiff_in;
      prod_ff    <= prod_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      lim_ff     <= lim_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      speed_ff   <= speed_in;
   end

   always_comb begin
      sts.emit_zero = emit_zero_ff;
      sts.emit_calc = emit_calc_ff;
      sts.div_skip  = over;
      sts.div_last  = (cnt_ff == '0);
   end

   assign rsp_speed = speed_ff;

endmodule

### hdl/wheel_speed_from_revolutions.sv
// Wheel speed from cumulative revolution counts.
// The request channel carries one wheel measurement per item: a presence flag,
// the cumulative revolution count and the last wheel event time in 1/1024 s.
// The response channel carries the speed in km/h, rounded half up, 0 to 999.
// An item with the flag clear, or one that falls inside the zero-motion hold
// window, produces no response; every other item produces exactly one.
// One item is processed at a time. A computed speed passes through a decision
// state, a multiply stage, a scaling stage, a divider setup step, a restoring
// divider that yields one quotient bit per cycle and a final step that loads
// the result into the output register. A zero speed result goes from the
// decision straight to the load, and an over-range speed skips the divider
// after its setup. An item with no result returns to idle straight from the
// decision, where the next item can be taken. Requests are taken again once
// the result sits in the output register, even while the receiver stalls it;
// a second result waits in the datapath until that register is read. The csr
// port writes the circumference and the hold limit, and is used only while the
// block is idle: the user is bound to this, as the block itself does not
// enforce it. Reset (synchronous) restores the default registers and forgets
// the previous sample, so the next measurement reports zero.
module wheel_speed_from_revolutions (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_wheel_present,
   input  logic [wsr_pkg::REVS_W-1:0]    req_wheel_revs,
   input  logic [wsr_pkg::TIME_W-1:0]    req_event_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wsr_pkg::SPEED_W-1:0]   rsp_speed,
   input  logic                          csr_wr_en,
   input  logic [wsr_pkg::IDX_W-1:0]     csr_index,
   input  logic [wsr_pkg::CSR_W-1:0]     csr_wdata
);
   import wsr_pkg::*;

   wsr_cmd_type cmd;
   wsr_sts_type sts;

   // The controller sequences the work and owns both handshakes.
   wsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the sample history, the configuration and the divider.
   wsr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_wheel_present (req_wheel_present),
      .req_wheel_revs    (req_wheel_revs),
      .req_event_time    (req_event_time),
      .rsp_speed         (rsp_speed)
   );

endmodule

### tb/sv/wheel_speed_from_revolutions_tb.sv
`timescale 1ns / 100ps

// Checks the wheel speed block against an in-line predictor of the speed
// calculation. Items go in through the request channel with random gaps, and
// results come out through the response channel with random stalls.
module wheel_speed_from_revolutions_tb;
   import wsr_pkg::*;

   // The run is aborted at this many cycles.
   localparam int CYCLE_LIMIT = 1000000;
   // This margin covers an item that is still in flight but will cause
   // no result.
   localparam int SETTLE_CYCLES = 24;
   // Measurements with the flag set, sent in each random phase.
   localparam int PHASE_ITEMS = 250;
   localparam logic [63:0] SPEED_LIMIT = 64'd999;
   localparam logic [63:0] SPEED_NUM_SCALE = 64'd2304;
   localparam logic [63:0] SPEED_DEN_SCALE = 64'd625;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_wheel_present;
   logic [REVS_W-1:0] req_wheel_revs;
   logic [TIME_W-1:0] req_event_time;
   logic rsp_valid;
   logic rsp_stall;
   logic [SPEED_W-1:0] rsp_speed;
   logic csr_wr_en;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   // Predictor state: the configuration as written and the stored sample.
   logic [CIRC_W-1:0] circ_mm = CIRC_RESET;
   logic [HOLD_W-1:0] hold_limit = HOLD_RESET;
   logic [REVS_W-1:0] prev_revs = '0;
   logic [TIME_W-1:0] prev_time = '0;
   logic [RUN_W-1:0] still_run = '0;
   logic have_sample = 1'b0;

   // Speeds that the block still owes, oldest first.
   logic [SPEED_W-1:0] speed_expected_q[$];
   logic [SPEED_W-1:0] speed_want;

   // Position of the simulated wheel, so that most items form a proper ride.
   logic [REVS_W-1:0] ride_revs = '0;
   logic [TIME_W-1:0] ride_time = '0;

   bit idle_on = 1'b1;
   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   int result_count = 0;

   wheel_speed_from_revolutions u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_wheel_present (req_wheel_present),
      .req_wheel_revs    (req_wheel_revs),
      .req_event_time    (req_event_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speed         (rsp_speed),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Every input starts at a known value, with reset asserted.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_wheel_present = 1'b0;
      req_wheel_revs = '0;
      req_event_time = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
   end

   // Most idle stretches are short, a few are long.
   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 16);
      end else begin
         return $urandom_range(20, 80);
      end
   endfunction

   // Rounded speed in km/h for one revolution and time difference. It is
   // revdiff * circ * 2304 / (625 * tdiff) rounded half up, and anything
   // above the display limit or with no elapsed time reads as zero.
   function automatic logic [SPEED_W-1:0] wheel_speed(logic [REVS_W-1:0] revdiff,
                                                      logic [TIME_W-1:0] tdiff);
      logic [63:0] num;
      logic [63:0] den;
      num = 64'(revdiff) * 64'(circ_mm) * SPEED_NUM_SCALE;
      den = SPEED_DEN_SCALE * 64'(tdiff);
      if (tdiff == '0) begin
         return '0;
      end else if (num > SPEED_LIMIT * den) begin
         return '0;
      end else begin
         return SPEED_W'((2 * num + den) / (2 * den));
      end
   endfunction

   // Updates the predictor for one accepted item and queues the speed that
   // the item causes, if any.
   task automatic predict_measurement(input logic present, input logic [REVS_W-1:0] revs,
                                      input logic [TIME_W-1:0] t);
      logic [REVS_W-1:0] rev_mask;
      logic [REVS_W-1:0] cur_revs;
      logic [REVS_W-1:0] revdiff;
      logic [TIME_W-1:0] tdiff;
      rev_mask = REVS_W'((65'd1 << REV_BITS) - 65'd1);
      cur_revs = revs & rev_mask;
      revdiff = (cur_revs - prev_revs) & rev_mask;
      tdiff = t - prev_time;
      if (present) begin
         // A run of standing samples counts up and stops one past the limit.
         if (revdiff == '0) begin
            if (still_run <= RUN_W'(hold_limit)) begin
               still_run = still_run + 1'b1;
            end
         end else begin
            still_run = '0;
         end
         // With no earlier sample, or after the hold window, the wheel is
         // reported as standing. Inside the window nothing is reported.
         if (!have_sample || still_run > RUN_W'(hold_limit)) begin
            speed_expected_q.push_back('0);
         end else if (still_run == '0) begin
            speed_expected_q.push_back(wheel_speed(revdiff, tdiff));
         end
         prev_revs = cur_revs;
         prev_time = t;
         have_sample = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR: cycle %0d, result %0d: %s", cycle_count, result_count, what);
      error_count++;
   endtask

   // Sends one item after a random gap and waits until it is accepted.
   // Valid is only lowered when a gap follows, so it is never dropped and
   // raised in the same step.
   task automatic send_measurement(input logic present, input logic [REVS_W-1:0] revs,
                                   input logic [TIME_W-1:0] t);
      int gap;
      gap = idle_on ? pick_idle() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_wheel_present <= present;
      req_wheel_revs <= revs;
      req_event_time <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_measurement(present, revs, t);
   endtask

   // Moves the simulated wheel on and reports where it is now.
   task automatic step_wheel(input logic [REVS_W-1:0] rev_inc, input logic [TIME_W-1:0] time_inc);
      ride_revs = ride_revs + rev_inc;
      ride_time = ride_time + time_inc;
      send_measurement(1'b1, ride_revs, ride_time);
   endtask

   // Stops sending and waits until every owed result has come, then lets the
   // block finish any item that causes no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (speed_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One write, then a pause with the write enable low, so that back-to-back
   // writes never touch the write enable twice in one step.
   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CIRC) begin
         circ_mm = data[CIRC_W-1:0];
      end else begin
         hold_limit = data[HOLD_W-1:0];
      end
      @(posedge clock);
   endtask

   // The hold limit is written with random upper bits, which the block drops.
   task automatic configure(input logic [CIRC_W-1:0] circ, input logic [HOLD_W-1:0] hold);
      wait_idle();
      write_register(CSR_CIRC, CSR_W'(circ));
      write_register(CSR_HOLD, {(CSR_W - HOLD_W)'($urandom), hold});
   endtask

   // Straight after reset there is no earlier sample, so the first item with
   // the flag set reports zero. An item with the flag clear is ignored.
   task automatic test_first_sample();
      send_measurement(1'b0, $urandom, TIME_W'($urandom));
      ride_revs = 32'h1234_5678;
      ride_time = 16'h0400;
      send_measurement(1'b1, ride_revs, ride_time);
   endtask

   // Directed speeds at the reset configuration: ordinary motion, a zero
   // time difference, an over-range speed, counters that wrap, a standing
   // run through the hold window and the largest differences of all.
   task automatic test_speed_cases();
      step_wheel(32'd1, 16'h0400);
      step_wheel(32'd5, 16'h0100);
      step_wheel(32'd1, 16'h0000);
      step_wheel(32'd3000, 16'h0001);
      send_measurement(1'b0, ~ride_revs, ~ride_time);
      ride_revs = 32'hFFFF_FFFE;
      ride_time = 16'hFFF0;
      send_measurement(1'b1, ride_revs, ride_time);
      step_wheel(32'd5, 16'h0400);
      repeat (4) step_wheel(32'd0, 16'h0200);
      step_wheel(32'd2, 16'h0300);
      step_wheel(32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // Largest and smallest circumference, zero circumference, and no hold.
   task automatic test_circumference_extremes();
      configure(12'd4095, 4'd0);
      step_wheel(32'd1, 16'h0040);
      step_wheel(32'd0, 16'h0040);
      step_wheel(32'd2, 16'h0100);
      configure(12'd0, 4'd2);
      step_wheel(32'd7, 16'h0020);
      configure(12'd1, 4'd2);
      step_wheel(32'd1, 16'h0001);
   endtask

   // A standing run built under the widest window, then the limit lowered
   // below it: the next standing sample reports zero at once.
   task automatic test_hold_lowered();
      configure(CIRC_RESET, 4'd15);
      step_wheel(32'd3, 16'h0200);
      repeat (5) step_wheel(32'd0, 16'h0100);
      wait_idle();
      write_register(CSR_HOLD, CSR_W'(2));
      step_wheel(32'd0, 16'h0100);
      step_wheel(32'd4, 16'h0180);
   endtask

   // Mostly a ride with random revolution and time steps, standing bursts
   // that can cross the hold window, plus random samples and ignored items.
   task automatic test_random_ride(input int items);
      int sent;
      int roll;
      int burst;
      logic [REVS_W-1:0] rev_inc;
      logic [TIME_W-1:0] time_inc;
      sent = 0;
      while (sent < items) begin
         roll = $urandom_range(0, 99);
         case ($urandom_range(0, 99)) inside
            [0:29]:  rev_inc = '0;
            [30:84]: rev_inc = REVS_W'($urandom_range(1, 4));
            [85:96]: rev_inc = REVS_W'($urandom_range(5, 60));
            default: rev_inc = $urandom;
         endcase
         case ($urandom_range(0, 99)) inside
            [0:2]:   time_inc = '0;
            [3:79]:  time_inc = TIME_W'($urandom_range(64, 4096));
            [80:94]: time_inc = TIME_W'($urandom_range(1, 63));
            default: time_inc = TIME_W'($urandom_range(4097, 65535));
         endcase
         if (roll < 8) begin
            send_measurement(1'b0, $urandom, TIME_W'($urandom));
         end else if (roll < 16) begin
            ride_revs = $urandom;
            ride_time = TIME_W'($urandom);
            send_measurement(1'b1, ride_revs, ride_time);
            sent++;
         end else if (roll < 22) begin
            burst = $urandom_range(1, int'(hold_limit) + 3);
            repeat (burst) step_wheel('0, time_inc);
            sent += burst;
         end else begin
            step_wheel(rev_inc, time_inc);
            sent++;
         end
         // Now and then the sender holds off until the block has caught up.
         if ($urandom_range(0, 199) == 0) begin
            wait_idle();
         end
      end
   endtask

   task automatic test_random();
      configure(CIRC_RESET, HOLD_RESET);
      test_random_ride(PHASE_ITEMS);
      configure(12'd4095, 4'd15);
      test_random_ride(PHASE_ITEMS);
      configure(12'd1, 4'd0);
      test_random_ride(PHASE_ITEMS);
      // One phase runs back to back with no gaps and no stalls.
      configure(CIRC_W'($urandom_range(1, 4095)), HOLD_W'($urandom));
      idle_on = 1'b0;
      test_random_ride(PHASE_ITEMS);
      configure(CIRC_W'($urandom_range(1, 4095)), HOLD_W'($urandom));
      idle_on = 1'b1;
      test_random_ride(PHASE_ITEMS);
   endtask

   // Result checker and receiver stalls. Both read the values from before
   // the edge, and the stall is driven once per edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count <= result_count + 1;
         if (speed_expected_q.size() == 0) begin
            report_mismatch($sformatf("speed %0d with no result owed", rsp_speed));
         end else begin
            speed_want = speed_expected_q.pop_front();
            if (rsp_speed !== speed_want) begin
               report_mismatch($sformatf("speed %0d, expected %0d",
                                         rsp_speed, speed_want));
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (idle_on && $urandom_range(0, 99) < 30) begin
            stall_left <= pick_idle();
         end
      end
   end

   // Watchdog for a block that hangs or never answers.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("wheel_speed_from_revolutions: mismatch");
         $finish;
      end
   end

   // Directed tests first, then the random phases. At the end the sender
   // stops, every owed speed must arrive, and a margin catches stray ones.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_first_sample();
      test_speed_cases();
      test_circumference_extremes();
      test_hold_lowered();
      test_random();
      wait_idle();
      if (speed_expected_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", speed_expected_q.size()));
      end
      if (error_count == 0) begin
         $display("wheel_speed_from_revolutions: match");
      end else begin
         $display("wheel_speed_from_revolutions: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/wsr_pkg.sv
hdl/wsr_ctrl.sv
hdl/wsr_dp.sv
hdl/wheel_speed_from_revolutions.sv
tb/sv/wheel_speed_from_revolutions_tb.sv
